// ===== hdl/hfx_pkg.sv =====
package hfx_pkg;

  // Sequencer step counter width and program steps
  localparam int PC_W = 5;

  localparam logic [PC_W-1:0] PC_CHK_NAN = 5'd0;
  localparam logic [PC_W-1:0] PC_CHK_INF = 5'd1;
  localparam logic [PC_W-1:0] PC_SIGN    = 5'd2;
  localparam logic [PC_W-1:0] PC_ZERO    = 5'd3;
  localparam logic [PC_W-1:0] PC_X       = 5'd4;
  localparam logic [PC_W-1:0] PC_LEAD    = 5'd5;
  localparam logic [PC_W-1:0] PC_DOT     = 5'd6;
  localparam logic [PC_W-1:0] PC_FRAC    = 5'd7;
  localparam logic [PC_W-1:0] PC_EXPO    = 5'd8;
  localparam logic [PC_W-1:0] PC_ESIGN   = 5'd9;
  localparam logic [PC_W-1:0] PC_E_THOU  = 5'd10;
  localparam logic [PC_W-1:0] PC_E_HUND  = 5'd11;
  localparam logic [PC_W-1:0] PC_E_TENS  = 5'd12;
  localparam logic [PC_W-1:0] PC_E_UNIT  = 5'd13;
  localparam logic [PC_W-1:0] PC_NAN     = 5'd14;
  localparam logic [PC_W-1:0] PC_NAN_A   = 5'd15;
  localparam logic [PC_W-1:0] PC_NAN_N   = 5'd16;
  localparam logic [PC_W-1:0] PC_INF     = 5'd17;
  localparam logic [PC_W-1:0] PC_INF_I   = 5'd18;
  localparam logic [PC_W-1:0] PC_INF_N   = 5'd19;
  localparam logic [PC_W-1:0] PC_INF_F   = 5'd20;

  // Number of fraction nibbles in the 52-bit field
  localparam int FRAC_NIB = 13;

  // Sign prefix modes for values with a clear sign bit
  localparam logic [1:0] SMODE_SPACE = 2'd1;
  localparam logic [1:0] SMODE_PLUS  = 2'd2;

  // Character source for one step
  typedef enum logic [2:0] {
    SRC_LIT,
    SRC_SIGN,
    SRC_LEAD,
    SRC_FRAC,
    SRC_ESIGN,
    SRC_EDIG
  } src_t;

  // When a step puts out a character
  typedef enum logic [2:0] {
    EC_NEVER,
    EC_ALWAYS,
    EC_PFX,
    EC_NEG,
    EC_EXPDIG
  } econd_t;

  // Jump condition
  typedef enum logic [2:0] {
    JC_NEVER,
    JC_NAN,
    JC_INF,
    JC_NODIG,
    JC_MOREDIG
  } jcond_t;

  // Decimal place of an exponent digit
  typedef enum logic [1:0] {
    PL_THOU,
    PL_HUND,
    PL_TENS,
    PL_UNIT
  } place_t;

  typedef struct packed {
    src_t            src;
    econd_t          econd;
    logic [7:0]      lit;
    jcond_t          jcond;
    logic [PC_W-1:0] target;
    place_t          place;
    logic            last;
    logic            done;
  } ctl_t;

  // Sequencer to datapath
  typedef struct packed {
    ctl_t ctl;
    logic emit;
    logic adv;
  } seq_out_t;

  // Datapath flags for the sequencer
  typedef struct packed {
    logic nan;
    logic inf;
    logic neg;
    logic pfx;
    logic nodig;
    logic moredig;
    logic expdig;
  } dp_stat_t;

  function automatic ctl_t mk(src_t s, econd_t ec, logic [7:0] l, jcond_t j,
                              logic [PC_W-1:0] t, place_t p, logic lst, logic dn);
    ctl_t c;
    c.src    = s;
    c.econd  = ec;
    c.lit    = l;
    c.jcond  = j;
    c.target = t;
    c.place  = p;
    c.last   = lst;
    c.done   = dn;
    return c;
  endfunction

  // Microprogram
  function automatic ctl_t ucode(logic [PC_W-1:0] pc);
    ctl_t c;
    case (pc)
      PC_CHK_NAN: c = mk(SRC_LIT,   EC_NEVER,  8'h00, JC_NAN,     PC_NAN,  PL_UNIT, 1'b0, 1'b0);
      PC_CHK_INF: c = mk(SRC_LIT,   EC_NEVER,  8'h00, JC_INF,     PC_INF,  PL_UNIT, 1'b0, 1'b0);
      PC_SIGN:    c = mk(SRC_SIGN,  EC_PFX,    8'h00, JC_NEVER,   PC_ZERO, PL_UNIT, 1'b0, 1'b0);
      PC_ZERO:    c = mk(SRC_LIT,   EC_ALWAYS, "0",   JC_NEVER,   PC_X,    PL_UNIT, 1'b0, 1'b0);
      PC_X:       c = mk(SRC_LIT,   EC_ALWAYS, "x",   JC_NEVER,   PC_LEAD, PL_UNIT, 1'b0, 1'b0);
      PC_LEAD:    c = mk(SRC_LEAD,  EC_ALWAYS, 8'h00, JC_NODIG,   PC_EXPO, PL_UNIT, 1'b0, 1'b0);
      PC_DOT:     c = mk(SRC_LIT,   EC_ALWAYS, ".",   JC_NEVER,   PC_FRAC, PL_UNIT, 1'b0, 1'b0);
      PC_FRAC:    c = mk(SRC_FRAC,  EC_ALWAYS, 8'h00, JC_MOREDIG, PC_FRAC, PL_UNIT, 1'b0, 1'b0);
      PC_EXPO:    c = mk(SRC_LIT,   EC_ALWAYS, "p",   JC_NEVER,   PC_ESIGN, PL_UNIT, 1'b0, 1'b0);
      PC_ESIGN:   c = mk(SRC_ESIGN, EC_ALWAYS, 8'h00, JC_NEVER,   PC_E_THOU, PL_UNIT, 1'b0, 1'b0);
      PC_E_THOU:  c = mk(SRC_EDIG,  EC_EXPDIG, 8'h00, JC_NEVER,   PC_E_HUND, PL_THOU, 1'b0, 1'b0);
      PC_E_HUND:  c = mk(SRC_EDIG,  EC_EXPDIG, 8'h00, JC_NEVER,   PC_E_TENS, PL_HUND, 1'b0, 1'b0);
      PC_E_TENS:  c = mk(SRC_EDIG,  EC_EXPDIG, 8'h00, JC_NEVER,   PC_E_UNIT, PL_TENS, 1'b0, 1'b0);
      PC_E_UNIT:  c = mk(SRC_EDIG,  EC_EXPDIG, 8'h00, JC_NEVER,   PC_CHK_NAN, PL_UNIT, 1'b1, 1'b1);
      PC_NAN:     c = mk(SRC_LIT,   EC_ALWAYS, "n",   JC_NEVER,   PC_NAN_A, PL_UNIT, 1'b0, 1'b0);
      PC_NAN_A:   c = mk(SRC_LIT,   EC_ALWAYS, "a",   JC_NEVER,   PC_NAN_N, PL_UNIT, 1'b0, 1'b0);
      PC_NAN_N:   c = mk(SRC_LIT,   EC_ALWAYS, "n",   JC_NEVER,   PC_CHK_NAN, PL_UNIT, 1'b1, 1'b1);
      PC_INF:     c = mk(SRC_LIT,   EC_NEG,    "-",   JC_NEVER,   PC_INF_I, PL_UNIT, 1'b0, 1'b0);
      PC_INF_I:   c = mk(SRC_LIT,   EC_ALWAYS, "i",   JC_NEVER,   PC_INF_N, PL_UNIT, 1'b0, 1'b0);
      PC_INF_N:   c = mk(SRC_LIT,   EC_ALWAYS, "n",   JC_NEVER,   PC_INF_F, PL_UNIT, 1'b0, 1'b0);
      PC_INF_F:   c = mk(SRC_LIT,   EC_ALWAYS, "f",   JC_NEVER,   PC_CHK_NAN, PL_UNIT, 1'b1, 1'b1);
      default:    c = mk(SRC_LIT,   EC_ALWAYS, "?",   JC_NEVER,   PC_CHK_NAN, PL_UNIT, 1'b1, 1'b1);
    endcase
    return c;
  endfunction

  // Hex digit to ASCII
  function automatic logic [7:0] hex_char(logic [3:0] nib, logic up);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else if (up) begin
      c = 8'h37 + {4'h0, nib};
    end else begin
      c = 8'h57 + {4'h0, nib};
    end
    return c;
  endfunction

  // Lower-case letter to upper case when asked
  function automatic logic [7:0] case_fix(logic [7:0] c, logic up);
    logic [7:0] r;
    r = c;
    if (up && c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

  // k times the weight of a decimal place
  function automatic logic [13:0] place_mul(place_t p, int unsigned k);
    logic [13:0] r;
    case (p)
      PL_THOU: r = 14'(k * 1000);
      PL_HUND: r = 14'(k * 100);
      PL_TENS: r = 14'(k * 10);
      PL_UNIT: r = 14'(k);
      default: r = 14'(k);
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/hfx_dp.sv =====
module hfx_dp #(
  parameter int MAX_PRECISION = 48
) (
  input  logic               clk,
  input  logic               start,
  input  logic [63:0]        in_value_bits,
  input  logic               in_upper_case,
  input  logic [1:0]         in_sign_mode,
  input  logic               in_precision_given,
  input  logic [5:0]         in_precision,
  input  hfx_pkg::seq_out_t  sq,
  output hfx_pkg::dp_stat_t  stat,
  output logic [7:0]         ch
);

  logic        neg_r, neg_nxt;
  logic        up_r, up_nxt;
  logic [1:0]  smode_r, smode_nxt;
  logic        nan_r, nan_nxt;
  logic        inf_r, inf_nxt;
  logic        lead_r, lead_nxt;
  logic [51:0] frac_r, frac_nxt;
  logic [5:0]  ndig_r, ndig_nxt;
  logic [5:0]  fi_r, fi_nxt;
  logic        eneg_r, eneg_nxt;
  logic [9:0]  mag_r, mag_nxt;
  logic        started_r, started_nxt;

  logic [10:0] bexp;
  logic [51:0] frac_in;
  logic [5:0]  nz_dig;
  logic [5:0]  sat_prec;
  logic [3:0]  edig;
  logic [13:0] esub;
  logic [9:0]  erem;
  logic [6:0]  fi_inc;

  assign bexp    = in_value_bits[62:52];
  assign frac_in = in_value_bits[51:0];

  // Digits up to the last non-zero fraction nibble
  always_comb begin
    nz_dig = 6'd0;
    for (int i = 1; i <= hfx_pkg::FRAC_NIB; i++) begin
      if (frac_in[55-4*i -: 4] != 4'h0) begin
        nz_dig = 6'(i);
      end
    end
  end

  assign sat_prec = (in_precision > 6'(MAX_PRECISION)) ? 6'(MAX_PRECISION) : in_precision;

  // Exponent digit at the current decimal place
  always_comb begin
    edig = 4'd0;
    esub = 14'd0;
    for (int unsigned k = 1; k <= 9; k++) begin
      if ({4'd0, mag_r} >= hfx_pkg::place_mul(sq.ctl.place, k)) begin
        edig = 4'(k);
        esub = hfx_pkg::place_mul(sq.ctl.place, k);
      end
    end
    erem = mag_r - esub[9:0];
  end

  assign fi_inc = {1'b0, fi_r} + 7'd1;

  // Status for the sequencer
  always_comb begin
    stat.nan     = nan_r;
    stat.inf     = inf_r;
    stat.neg     = neg_r;
    stat.pfx     = neg_r || (smode_r == hfx_pkg::SMODE_PLUS) ||
                   (smode_r == hfx_pkg::SMODE_SPACE);
    stat.nodig   = (ndig_r == 6'd0);
    stat.moredig = (fi_inc != {1'b0, ndig_r});
    stat.expdig  = (edig != 4'd0) || started_r || (sq.ctl.place == hfx_pkg::PL_UNIT);
  end

  // Character select
  always_comb begin
    case (sq.ctl.src)
      hfx_pkg::SRC_LIT:   ch = hfx_pkg::case_fix(sq.ctl.lit, up_r);
      hfx_pkg::SRC_SIGN:  ch = neg_r ? "-" : ((smode_r == hfx_pkg::SMODE_PLUS) ? "+" : " ");
      hfx_pkg::SRC_LEAD:  ch = hfx_pkg::hex_char({3'b000, lead_r}, up_r);
      hfx_pkg::SRC_FRAC:  ch = hfx_pkg::hex_char(frac_r[51:48], up_r);
      hfx_pkg::SRC_ESIGN: ch = eneg_r ? "-" : "+";
      hfx_pkg::SRC_EDIG:  ch = 8'h30 + {4'h0, edig};
      default:            ch = "?";
    endcase
  end

  // Operand load and per-step update
  always_comb begin
    neg_nxt     = neg_r;
    up_nxt      = up_r;
    smode_nxt   = smode_r;
    nan_nxt     = nan_r;
    inf_nxt     = inf_r;
    lead_nxt    = lead_r;
    frac_nxt    = frac_r;
    ndig_nxt    = ndig_r;
    fi_nxt      = fi_r;
    eneg_nxt    = eneg_r;
    mag_nxt     = mag_r;
    started_nxt = started_r;
    if (start) begin
      neg_nxt     = in_value_bits[63];
      up_nxt      = in_upper_case;
      smode_nxt   = in_sign_mode;
      nan_nxt     = (bexp == 11'h7FF) && (frac_in != 52'd0);
      inf_nxt     = (bexp == 11'h7FF) && (frac_in == 52'd0);
      lead_nxt    = (bexp != 11'd0);
      frac_nxt    = frac_in;
      ndig_nxt    = in_precision_given ? sat_prec : nz_dig;
      fi_nxt      = 6'd0;
      started_nxt = 1'b0;
      if (bexp != 11'd0) begin
        eneg_nxt = (bexp < 11'd1023);
        mag_nxt  = (bexp < 11'd1023) ? 10'(11'd1023 - bexp) : 10'(bexp - 11'd1023);
      end else begin
        eneg_nxt = (frac_in != 52'd0);
        mag_nxt  = (frac_in != 52'd0) ? 10'd1022 : 10'd0;
      end
    end else if (sq.adv) begin
      if (sq.ctl.src == hfx_pkg::SRC_FRAC && sq.emit) begin
        frac_nxt = {frac_r[47:0], 4'h0};
        fi_nxt   = fi_inc[5:0];
      end
      if (sq.ctl.src == hfx_pkg::SRC_EDIG) begin
        mag_nxt = erem;
        if (sq.emit) begin
          started_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    neg_r     <= neg_nxt;
    up_r      <= up_nxt;
    smode_r   <= smode_nxt;
    nan_r     <= nan_nxt;
    inf_r     <= inf_nxt;
    lead_r    <= lead_nxt;
    frac_r    <= frac_nxt;
    ndig_r    <= ndig_nxt;
    fi_r      <= fi_nxt;
    eneg_r    <= eneg_nxt;
    mag_r     <= mag_nxt;
    started_r <= started_nxt;
  end

endmodule

// ===== hdl/hfx_seq.sv =====
module hfx_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              out_free,
  input  hfx_pkg::dp_stat_t stat,
  output hfx_pkg::seq_out_t sq,
  output logic              busy
);

  logic [hfx_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                     busy_r, busy_nxt;
  hfx_pkg::ctl_t            ctl;
  logic                     emit;
  logic                     jump;
  logic                     adv;

  // Control word for the current step
  assign ctl = hfx_pkg::ucode(pc_r);

  // Emit condition
  always_comb begin
    case (ctl.econd)
      hfx_pkg::EC_NEVER:  emit = 1'b0;
      hfx_pkg::EC_ALWAYS: emit = 1'b1;
      hfx_pkg::EC_PFX:    emit = stat.pfx;
      hfx_pkg::EC_NEG:    emit = stat.neg;
      hfx_pkg::EC_EXPDIG: emit = stat.expdig;
      default:            emit = 1'b0;
    endcase
  end

  // Jump condition
  always_comb begin
    case (ctl.jcond)
      hfx_pkg::JC_NEVER:   jump = 1'b0;
      hfx_pkg::JC_NAN:     jump = stat.nan;
      hfx_pkg::JC_INF:     jump = stat.inf;
      hfx_pkg::JC_NODIG:   jump = stat.nodig;
      hfx_pkg::JC_MOREDIG: jump = stat.moredig;
      default:             jump = 1'b0;
    endcase
  end

  // A step completes unless its character finds the output register full
  assign adv = busy_r && (!emit || out_free);

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (start) begin
      pc_nxt   = hfx_pkg::PC_CHK_NAN;
      busy_nxt = 1'b1;
    end else if (adv) begin
      pc_nxt = jump ? ctl.target : pc_r + 1'b1;
      if (ctl.done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= hfx_pkg::PC_CHK_NAN;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign sq.ctl  = ctl;
  assign sq.emit = emit;
  assign sq.adv  = adv;
  assign busy    = busy_r;

endmodule

// ===== hdl/double_to_hex_float_text.sv =====
// One microprogram step per cycle unless output back-pressure stalls a step that emits;
// a suppressed leading exponent zero leaves a gap in the output.
// Synchronous active-low reset clears the sequencer and the output valid only.
module double_to_hex_float_text #(
  parameter int MAX_PRECISION = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_value_bits,
  input  logic        in_upper_case,
  input  logic [1:0]  in_sign_mode,
  input  logic        in_precision_given,
  input  logic [5:0]  in_precision,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        out_last_char
);

  hfx_pkg::seq_out_t sq;
  hfx_pkg::dp_stat_t stat;
  logic              busy;
  logic              start;
  logic              out_free;
  logic [7:0]        ch;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;

  // Take a new request only when the sequencer is free
  assign in_ready = !busy;
  assign start    = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  hfx_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_free (out_free),
    .stat     (stat),
    .sq       (sq),
    .busy     (busy)
  );

  hfx_dp #(
    .MAX_PRECISION (MAX_PRECISION)
  ) u_dp (
    .clk                (clk),
    .start              (start),
    .in_value_bits      (in_value_bits),
    .in_upper_case      (in_upper_case),
    .in_sign_mode       (in_sign_mode),
    .in_precision_given (in_precision_given),
    .in_precision       (in_precision),
    .sq                 (sq),
    .stat               (stat),
    .ch                 (ch)
  );

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (sq.adv && sq.emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = ch;
      out_last_nxt  = sq.ctl.last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_last_char = out_last_r;

`ifndef SYNTHESIS
  // An accepted request always starts the sequencer
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> busy)
    else $error("sequencer not busy after request");

  // Program ends only on a character that is emitted and marked last
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (sq.adv && sq.ctl.done) |-> (sq.emit && sq.ctl.last))
    else $error("program ended without a last character");

  // A character is never loaded over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (sq.adv && sq.emit) |-> out_free)
    else $error("output register overwritten");
`endif

endmodule
